// ===== src/sapq_pkg.sv =====
package sapq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int KEY_W = 16;
  localparam int TAG_W = 16;
  localparam int OCC_W = 7;
  localparam int STATUS_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic             opcode;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } in_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]    out_key;
    logic [TAG_W-1:0]    out_tag;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input word, pos <= count
    logic rd_first;   // read entry count-1
    logic rd_next;    // read entry pos-2
    logic wr_shift;   // write read data to pos, pos--
    logic wr_new;     // write new entry at pos
    logic count_inc;
    logic count_dec;
    logic res_ok;
    logic res_empty;
    logic res_full;
    logic res_rem;    // result from read data
    logic out_load;
  } sapq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic pos_zero;
    logic pos_one;
    logic key_gt;     // read key > new key
  } sapq_sts_t;

endpackage

// ===== src/sapq_ram.sv =====
module sapq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/sapq_datapath.sv =====
module sapq_datapath #(
  parameter int QUEUE_DEPTH = sapq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sapq_pkg::in_word_t  in_data,
  input  sapq_pkg::sapq_cmd_t cmd,
  output sapq_pkg::sapq_sts_t sts,
  output sapq_pkg::out_word_t out_data
);
  import sapq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int DW = KEY_W + TAG_W;

  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [KEY_W-1:0]    key_r;
  logic [TAG_W-1:0]    tag_r;
  logic [KEY_W-1:0]    res_key_r, res_key_nxt;
  logic [TAG_W-1:0]    res_tag_r, res_tag_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  out_word_t           out_r, out_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;
  logic [KEY_W-1:0] rd_key;
  logic [TAG_W-1:0] rd_tag;

  assign rd_key = ram_rdata[DW-1:TAG_W];
  assign rd_tag = ram_rdata[TAG_W-1:0];

  assign ram_we    = cmd.wr_shift | cmd.wr_new;
  assign ram_wdata = cmd.wr_new ? {key_r, tag_r} : ram_rdata;
  assign ram_re    = cmd.rd_first | cmd.rd_next;
  assign ram_raddr = cmd.rd_first ? AW'(count_r - CW'(1)) : AW'(pos_r - AW'(2));

  sapq_ram #(
    .WIDTH(DW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pos_r),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign sts.empty    = (count_r == '0);
  assign sts.full     = (count_r == CW'(QUEUE_DEPTH));
  assign sts.pos_zero = (pos_r == '0);
  assign sts.pos_one  = (pos_r == AW'(1));
  assign sts.key_gt   = (rd_key > key_r);

  always_comb begin
    count_nxt = count_r;
    if (cmd.count_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.count_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.load) begin
      pos_nxt = AW'(count_r);
    end else if (cmd.wr_shift) begin
      pos_nxt = pos_r - AW'(1);
    end
  end

  always_comb begin
    res_key_nxt    = res_key_r;
    res_tag_nxt    = res_tag_r;
    res_status_nxt = res_status_r;
    if (cmd.res_rem) begin
      res_key_nxt    = rd_key;
      res_tag_nxt    = rd_tag;
      res_status_nxt = STATUS_OK;
    end else if (cmd.res_ok || cmd.res_empty || cmd.res_full) begin
      res_key_nxt    = '0;
      res_tag_nxt    = '0;
      res_status_nxt = cmd.res_empty ? STATUS_EMPTY :
                       cmd.res_full  ? STATUS_FULL  : STATUS_OK;
    end
  end

  always_comb begin
    out_nxt = out_r;
    if (cmd.out_load) begin
      out_nxt.out_key   = res_key_r;
      out_nxt.out_tag   = res_tag_r;
      out_nxt.status    = res_status_r;
      out_nxt.occupancy = OCC_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    res_key_r    <= res_key_nxt;
    res_tag_r    <= res_tag_nxt;
    res_status_r <= res_status_nxt;
    out_r        <= out_nxt;
    if (cmd.load) begin
      key_r <= in_data.key;
      tag_r <= in_data.tag;
    end
  end

  assign out_data = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_no_inc_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.count_inc |-> !sts.full)
    else $error("entry count raised on a full queue");

endmodule

// ===== src/sapq_ctrl.sv =====
module sapq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_opcode,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  sapq_pkg::sapq_sts_t sts,
  output sapq_pkg::sapq_cmd_t cmd
);
  import sapq_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_INS_WAIT = 3'd1;
  localparam logic [2:0] ST_INS_PUT  = 3'd2;
  localparam logic [2:0] ST_REM_WAIT = 3'd3;
  localparam logic [2:0] ST_FIN      = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_opcode == OP_INSERT) begin
            if (sts.full) begin
              cmd.res_full = 1'b1;
              state_nxt    = ST_FIN;
            end else if (sts.empty) begin
              state_nxt = ST_INS_PUT;
            end else begin
              cmd.rd_first = 1'b1;
              state_nxt    = ST_INS_WAIT;
            end
          end else begin
            if (sts.empty) begin
              cmd.res_empty = 1'b1;
              state_nxt     = ST_FIN;
            end else begin
              cmd.rd_first = 1'b1;
              state_nxt    = ST_REM_WAIT;
            end
          end
        end
      end
      ST_INS_WAIT: begin
        // read data holds entry pos-1
        if (sts.key_gt) begin
          cmd.wr_shift = 1'b1;
          if (sts.pos_one) begin
            state_nxt = ST_INS_PUT;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end else begin
          cmd.wr_new    = 1'b1;
          cmd.count_inc = 1'b1;
          cmd.res_ok    = 1'b1;
          state_nxt     = ST_FIN;
        end
      end
      ST_INS_PUT: begin
        cmd.wr_new    = 1'b1;
        cmd.count_inc = 1'b1;
        cmd.res_ok    = 1'b1;
        state_nxt     = ST_FIN;
      end
      ST_REM_WAIT: begin
        cmd.res_rem   = 1'b1;
        cmd.count_dec = 1'b1;
        state_nxt     = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_shift && cmd.wr_new))
    else $error("two writes in one cycle");

  a_shift_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS_WAIT) |-> !sts.pos_zero)
    else $error("shift below entry zero");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ST_IDLE))
    else $error("accepted word not processed");

  a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result loaded but not presented");

endmodule

// ===== src/sorted_array_priority_queue.sv =====
// Channel  Ports                         Word        Moves when
// in       in_valid, in_ready, in_data    in_word_t   in_valid & in_ready
// out      out_valid, out_ready, out_data out_word_t  out_valid & out_ready
//
// Remove: accept (entry read issued), entry read, result load. Insert: accept, then a
// compare-and-shift step per stored entry with a larger key, new-entry write, result
// load. Remove on empty and insert on full: accept, then result load. The result load
// waits while an unread result is held. One word is in process at a time;
// the next is taken once the result is registered, even while out_ready is low.
// Reset (rst_n low, synchronous) empties the queue; no clearing pass.
module sorted_array_priority_queue #(
  parameter int QUEUE_DEPTH = sapq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sapq_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sapq_pkg::out_word_t out_data
);
  import sapq_pkg::*;

  sapq_cmd_t cmd;
  sapq_sts_t sts;

  sapq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_opcode(in_data.opcode),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sapq_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .out_data(out_data)
  );

endmodule

// ===== tb/sapq_checker.sv =====
`timescale 1ns / 1ps

module sapq_checker #(
  parameter int DEPTH = sapq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  sapq_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  sapq_pkg::out_word_t out_data,
  output int                  fail_count,
  output int                  pending
);
  import sapq_pkg::*;

  // shadow copy of the sorted entry array, ascending keys
  logic [KEY_W-1:0] shadow_key [DEPTH];
  logic [TAG_W-1:0] shadow_tag [DEPTH];
  int               shadow_count = 0;

  out_word_t awaited_results [$];
  out_word_t oldest;
  int        errors = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic out_word_t apply_to_shadow(in_word_t w);
    out_word_t r;
    int        pos;
    r = '0;
    if (w.opcode == OP_INSERT) begin
      if (shadow_count >= DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        // equal keys stay below the new entry, so the newest leaves first
        pos = shadow_count;
        while (pos > 0 && shadow_key[pos-1] > w.key) begin
          shadow_key[pos] = shadow_key[pos-1];
          shadow_tag[pos] = shadow_tag[pos-1];
          pos--;
        end
        shadow_key[pos] = w.key;
        shadow_tag[pos] = w.tag;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        shadow_count--;
        r.out_key = shadow_key[shadow_count];
        r.out_tag = shadow_tag[shadow_count];
      end
    end
    r.occupancy = OCC_W'(shadow_count);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_count = 0;
      awaited_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        awaited_results.push_back(apply_to_shadow(in_data));
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result word with no pending expectation: 0x%0h", out_data);
          errors++;
        end else begin
          oldest = awaited_results.pop_front();
          check_field("out_key", oldest.out_key, out_data.out_key);
          check_field("out_tag", oldest.out_tag, out_data.out_tag);
          check_field("status", oldest.status, out_data.status);
          check_field("occupancy", oldest.occupancy, out_data.occupancy);
        end
      end
    end
    fail_count <= errors;
    pending    <= awaited_results.size();
  end

endmodule

// ===== tb/tb_sorted_array_priority_queue.sv =====
`timescale 1ns / 1ps

module tb_sorted_array_priority_queue;
  import sapq_pkg::*;

  localparam int DEPTH       = QUEUE_DEPTH_DEF;
  localparam int NUM_WORDS   = 1050;
  localparam int TAIL_CYCLES = DEPTH + 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_START  = 1500;
  localparam int HOLD_LEN    = 400;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  int        fail_count;
  int        pending;

  int cycle_count = 0;
  int words_sent = 0;
  bit no_idle = 1'b0;

  always #10 clk = ~clk;

  sorted_array_priority_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  sapq_checker #(
    .DEPTH(DEPTH)
  ) i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(input int mode);
    case (mode)
      1: return KEY_W'($urandom_range(0, 15));
      2: begin
        case ($urandom_range(0, 5))
          0: return '0;
          1: return KEY_W'(1);
          2: return '1;
          3: return {1'b0, {(KEY_W-1){1'b1}}};
          4: return {1'b1, {(KEY_W-1){1'b0}}};
          default: return {{(KEY_W-1){1'b1}}, 1'b0};
        endcase
      end
      3: return {8'hFF, 8'($urandom_range(0, 255))};
      default: return KEY_W'($urandom());
    endcase
  endfunction

  function automatic in_word_t ins(input logic [KEY_W-1:0] k, input logic [TAG_W-1:0] t);
    in_word_t w;
    w.opcode = OP_INSERT;
    w.key    = k;
    w.tag    = t;
    return w;
  endfunction

  // key and tag carry junk on a remove; the block must ignore them
  function automatic in_word_t rem();
    in_word_t w;
    w.opcode = OP_REMOVE;
    w.key    = KEY_W'($urandom());
    w.tag    = TAG_W'($urandom());
    return w;
  endfunction

  task automatic offer_word(input in_word_t w);
    int gap;
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random stalls, calm stretches, and one long hold-off
  initial begin : result_side
    int  cyc;
    int  stall_left;
    bit  calm;
    cyc        = 0;
    stall_left = 0;
    calm       = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (cyc % 500 == 0) calm = ($urandom_range(0, 3) == 0);
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
      cyc++;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    int ins_pct;
    int key_mode;
    int phase_len;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty removes, key extremes, equal-key ordering, drain past empty
    offer_word(rem());
    offer_word({OP_REMOVE, {KEY_W{1'b1}}, {TAG_W{1'b1}}});
    offer_word(ins(16'hFFFF, 16'h0000));
    offer_word(ins(16'h0000, 16'hFFFF));
    offer_word(ins(16'h8000, 16'h0001));
    offer_word(ins(16'h8000, 16'h0002));
    offer_word(ins(16'h8000, 16'h0003));
    offer_word(ins(16'h7FFF, 16'hAAAA));
    offer_word(ins(16'h0001, 16'h5555));
    offer_word(ins(16'hFFFF, 16'hFFFF));
    repeat (10) offer_word(rem());

    // fill to the top with back-to-back words, then push against full
    no_idle = 1'b1;
    repeat (DEPTH) offer_word(ins(pick_key(1), TAG_W'($urandom())));
    no_idle = 1'b0;
    repeat (3) offer_word(ins(pick_key(0), TAG_W'($urandom())));
    offer_word(rem());
    offer_word(ins(pick_key(2), TAG_W'($urandom())));
    offer_word(ins(pick_key(2), TAG_W'($urandom())));
    repeat (DEPTH + 2) offer_word(rem());

    // random phases steer occupancy up and down between empty and full
    while (words_sent < NUM_WORDS) begin
      case ($urandom_range(0, 2))
        0: ins_pct = 25;
        1: ins_pct = 50;
        default: ins_pct = 80;
      endcase
      key_mode  = $urandom_range(0, 3);
      phase_len = $urandom_range(20, 120);
      no_idle   = ($urandom_range(0, 4) == 0);
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < ins_pct) begin
          offer_word(ins(pick_key(key_mode), TAG_W'($urandom())));
        end else begin
          offer_word(rem());
        end
      end
    end
    in_valid <= 1'b0;

    // pending is a registered copy of the checker's count of awaited results
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/sapq_pkg.sv
src/sapq_ram.sv
src/sapq_datapath.sv
src/sapq_ctrl.sv
src/sorted_array_priority_queue.sv
tb/sapq_checker.sv
tb/tb_sorted_array_priority_queue.sv
